/* rtl/csn_pkg.sv */
// shared types, constants and cosine table function for the noise synthesizer
`timescale 1ns / 1ps

package csn_pkg;

    // default sizing
    localparam int MAX_POINTS_DEF     = 256;
    localparam int COS_TABLE_BITS_DEF = 10;

    // field widths
    localparam int ACTIVE_W = 9;
    localparam int GAIN_W   = 16;
    localparam int INDEX_W  = 8;
    localparam int FREQ_W   = 32;
    localparam int VALUE_W  = 16;
    localparam int TIME_W   = 32;
    localparam int AMP_W    = 24;
    localparam int COS_W    = 16;
    localparam int NOISE_W  = 32;

    // configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_POINTS = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN          = 4'd1;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 9'd0;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd256;

    // request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    // 2*pi in Q3.30
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    typedef struct packed {
        logic                       req_type;
        logic [INDEX_W-1:0]         entry_index;
        logic [FREQ_W-1:0]          entry_freq;
        logic signed [VALUE_W-1:0]  entry_value;
        logic [TIME_W-1:0]          eval_time;
    } req_t;

    typedef struct packed {
        logic signed [NOISE_W-1:0]  noise_value;
        logic                       saturated;
    } result_t;

    typedef enum logic [2:0] {
        CSN_IDLE,
        CSN_LOAD,
        CSN_ISSUE,
        CSN_DRAIN,
        CSN_FINISH
    } state_t;

    // one cosine table sample in Q1.15, evaluated at elaboration
    function automatic logic signed [COS_W-1:0] cos_entry(input int k, input int bits);
        logic [1:0]  q;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] t;
        logic        want_sin;
        longint      sum;
        longint      v;
        int          n;
        int          a;
        q        = 2'((k >> (bits - 2)) & 3);
        r        = 64'(k & ((1 << (bits - 2)) - 1));
        x        = (r * TWO_PI_Q30) >> bits;
        want_sin = (q == 2'd1) || (q == 2'd3);
        t        = want_sin ? x : (64'd1 << 30);
        sum      = longint'(t);
        // taylor series, one term per step
        for (n = 1; n <= 8; n++)
        begin
            a = want_sin ? 2 * n : 2 * n - 1;
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            case (a)
                1:       t = t / 64'd2;
                2:       t = t / 64'd6;
                3:       t = t / 64'd12;
                4:       t = t / 64'd20;
                5:       t = t / 64'd30;
                6:       t = t / 64'd42;
                7:       t = t / 64'd56;
                8:       t = t / 64'd72;
                9:       t = t / 64'd90;
                10:      t = t / 64'd110;
                11:      t = t / 64'd132;
                12:      t = t / 64'd156;
                13:      t = t / 64'd182;
                14:      t = t / 64'd210;
                15:      t = t / 64'd240;
                16:      t = t / 64'd272;
                default: t = t;
            endcase
            if (n[0])
                sum = sum - longint'(t);
            else
                sum = sum + longint'(t);
        end
        // round to q1.15 and clamp
        v = (sum < 0) ? 64'sd0 : sum;
        v = (v + 64'sd16384) >>> 15;
        if (v > 64'sd32767)
            v = 64'sd32767;
        if ((q == 2'd1) || (q == 2'd2))
            return COS_W'(-v);
        else
            return COS_W'(v);
    endfunction

endpackage

/* rtl/cosine_sum_noise_synth_top.sv */
// Sum-of-cosines noise synthesizer with spectrum table held in block ram.
// Load beat: busy in the load state after accept, entry written at the end of it; next beat once idle.
// Evaluate beat: issue, drain and finish states, then done pulses (no issue when N is 0), with
// N = min(active_points, MAX_POINTS); one table entry read and multiply-accumulated per cycle
// through a 4-stage ram / phase / cosine rom / product pipeline; next beat taken in done cycle.
// Reset: active_points 0, gain 256; table memories not cleared. Result is never stalled.
`timescale 1ns / 1ps

module cosine_sum_noise_synth_top #(
    parameter int MAX_POINTS     = csn_pkg::MAX_POINTS_DEF,
    parameter int COS_TABLE_BITS = csn_pkg::COS_TABLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  csn_pkg::req_t                       req,
    output logic                                done,
    output csn_pkg::result_t                    result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [csn_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [csn_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int AW      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW      = $clog2(MAX_POINTS + 1);
    localparam int PROD_W  = csn_pkg::AMP_W + csn_pkg::COS_W;
    localparam int ACC_RAW = PROD_W + $clog2(MAX_POINTS);
    localparam int ACC_W   = (ACC_RAW > 48) ? ACC_RAW : 48;
    localparam int SH_W    = ACC_W - 15;
    localparam int LP_W    = csn_pkg::VALUE_W + csn_pkg::GAIN_W + 1;
    localparam logic signed [SH_W-1:0] RES_MAX = SH_W'(64'sh7FFFFFFF);
    localparam logic signed [SH_W-1:0] RES_MIN = SH_W'(-64'sh80000000);
    localparam logic signed [LP_W-9:0] AMP_MAX = (LP_W-8)'(64'sd8388607);
    localparam logic signed [LP_W-9:0] AMP_MIN = (LP_W-8)'(-64'sd8388608);

    // configuration registers
    logic [csn_pkg::ACTIVE_W-1:0] active_points_reg;
    logic [csn_pkg::GAIN_W-1:0]   gain_reg;

    // control
    csn_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   n_reg;
    logic [CW-1:0]   n_next;
    logic            accept;
    logic            issue;
    logic            ram_we;
    logic            finish;
    logic            last_issue;
    logic            any_valid;

    // pipeline valids
    logic rd_valid_reg, ph_valid_reg, cos_valid_reg, prod_valid_reg;

    // load path
    logic signed [LP_W-1:0]            load_prod_reg;
    logic [AW-1:0]                     load_addr_reg;
    logic [csn_pkg::FREQ_W-1:0]        load_freq_reg;
    logic                              load_ok_reg;
    logic signed [LP_W-9:0]            load_shift;
    logic [csn_pkg::AMP_W-1:0]         amp_wdata;

    // evaluate path
    logic [csn_pkg::TIME_W-1:0]        time_reg;
    logic [csn_pkg::FREQ_W-1:0]        freq_rdata;
    logic [csn_pkg::AMP_W-1:0]         amp_rdata;
    logic [31:0]                       phase;
    logic [COS_TABLE_BITS-1:0]         ph_idx_reg;
    logic signed [csn_pkg::AMP_W-1:0]  amp_s1_reg;
    logic signed [csn_pkg::AMP_W-1:0]  amp_s2_reg;
    logic signed [csn_pkg::COS_W-1:0]  cos_rdata;
    logic signed [PROD_W-1:0]          prod_reg;
    logic signed [ACC_W-1:0]           acc_reg;
    logic signed [SH_W-1:0]            acc_shift;

    // result
    csn_pkg::result_t result_reg;
    logic             done_reg;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // clamp point count to table depth
    assign n_next = (32'(active_points_reg) > 32'(MAX_POINTS)) ?
                    CW'(MAX_POINTS) : CW'(active_points_reg);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_points_reg <= csn_pkg::ACTIVE_RESET;
            gain_reg          <= csn_pkg::GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                csn_pkg::CFG_ACTIVE_POINTS: active_points_reg <= cfg_data[csn_pkg::ACTIVE_W-1:0];
                csn_pkg::CFG_GAIN:          gain_reg          <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // fsm next state
    assign last_issue = ((cnt_reg + CW'(1)) == n_reg);
    assign any_valid  = rd_valid_reg || ph_valid_reg || cos_valid_reg || prod_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            csn_pkg::CSN_IDLE:
            begin
                if (accept)
                begin
                    if (req.req_type == csn_pkg::REQ_LOAD)
                        state_next = csn_pkg::CSN_LOAD;
                    else if (n_next == '0)
                        state_next = csn_pkg::CSN_DRAIN;
                    else
                        state_next = csn_pkg::CSN_ISSUE;
                end
            end
            csn_pkg::CSN_LOAD:   state_next = csn_pkg::CSN_IDLE;
            csn_pkg::CSN_ISSUE:
            begin
                if (last_issue)
                    state_next = csn_pkg::CSN_DRAIN;
            end
            csn_pkg::CSN_DRAIN:
            begin
                if (!any_valid)
                    state_next = csn_pkg::CSN_FINISH;
            end
            csn_pkg::CSN_FINISH: state_next = csn_pkg::CSN_IDLE;
            default:             state_next = csn_pkg::CSN_IDLE;
        endcase
    end

    // fsm outputs
    always_comb
    begin
        busy   = (state_reg != csn_pkg::CSN_IDLE);
        issue  = (state_reg == csn_pkg::CSN_ISSUE);
        ram_we = (state_reg == csn_pkg::CSN_LOAD) && load_ok_reg;
        finish = (state_reg == csn_pkg::CSN_FINISH);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= csn_pkg::CSN_IDLE;
            cnt_reg        <= '0;
            n_reg          <= '0;
            rd_valid_reg   <= 1'b0;
            ph_valid_reg   <= 1'b0;
            cos_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_valid_reg   <= issue;
            ph_valid_reg   <= rd_valid_reg;
            cos_valid_reg  <= ph_valid_reg;
            prod_valid_reg <= cos_valid_reg;
            done_reg       <= finish;
            if (accept)
            begin
                cnt_reg <= '0;
                n_reg   <= n_next;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
        end
    end

    // load beat capture: scale amplitude by gain
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            load_prod_reg <= LP_W'(req.entry_value) * LP_W'($signed({1'b0, gain_reg}));
            load_addr_reg <= AW'(req.entry_index);
            load_freq_reg <= req.entry_freq;
            load_ok_reg   <= (32'(req.entry_index) < 32'(MAX_POINTS));
            time_reg      <= req.eval_time;
        end
    end

    // floor divide by 256 and saturate to 24 bits
    always_comb
    begin
        load_shift = load_prod_reg[LP_W-1:8];
        if (load_shift > AMP_MAX)
            amp_wdata = AMP_MAX[csn_pkg::AMP_W-1:0];
        else if (load_shift < AMP_MIN)
            amp_wdata = AMP_MIN[csn_pkg::AMP_W-1:0];
        else
            amp_wdata = load_shift[csn_pkg::AMP_W-1:0];
    end

    // spectrum table memories
    csn_ram #(
        .WIDTH (csn_pkg::FREQ_W),
        .DEPTH (MAX_POINTS)
    ) u_freq_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (load_addr_reg),
        .wdata (load_freq_reg),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (freq_rdata)
    );

    csn_ram #(
        .WIDTH (csn_pkg::AMP_W),
        .DEPTH (MAX_POINTS)
    ) u_amp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (load_addr_reg),
        .wdata (amp_wdata),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (amp_rdata)
    );

    // phase stage: fractional part of freq * time
    assign phase = freq_rdata * time_reg;

    always_ff @(posedge clk)
    begin
        ph_idx_reg <= phase[31 -: COS_TABLE_BITS];
        amp_s1_reg <= $signed(amp_rdata);
        amp_s2_reg <= amp_s1_reg;
    end

    // cosine lookup stage
    csn_cos_rom #(
        .TABLE_BITS (COS_TABLE_BITS)
    ) u_cos_rom (
        .clk  (clk),
        .addr (ph_idx_reg),
        .data (cos_rdata)
    );

    // product and accumulate
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(amp_s2_reg) * PROD_W'(cos_rdata);
        if (accept)
            acc_reg <= '0;
        else if (prod_valid_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    // final scaling and saturation
    assign acc_shift = acc_reg[ACC_W-1:15];

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            if (acc_shift > RES_MAX)
            begin
                result_reg.noise_value <= RES_MAX[csn_pkg::NOISE_W-1:0];
                result_reg.saturated   <= 1'b1;
            end
            else if (acc_shift < RES_MIN)
            begin
                result_reg.noise_value <= RES_MIN[csn_pkg::NOISE_W-1:0];
                result_reg.saturated   <= 1'b1;
            end
            else
            begin
                result_reg.noise_value <= acc_shift[csn_pkg::NOISE_W-1:0];
                result_reg.saturated   <= 1'b0;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    // result beat only follows the finish state
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == csn_pkg::CSN_FINISH))
        else $error("result beat without finish");

    // evaluate beat always enters the read sequence
    a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.req_type == csn_pkg::REQ_EVAL) |=>
        (state_reg == csn_pkg::CSN_ISSUE || state_reg == csn_pkg::CSN_DRAIN))
        else $error("evaluate beat did not start");

    // read counter stays inside the point count
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == csn_pkg::CSN_ISSUE) |-> (cnt_reg < n_reg))
        else $error("read index beyond point count");

    // products only arrive while an evaluation is in flight
    a_prod_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid_reg |->
        (state_reg == csn_pkg::CSN_ISSUE || state_reg == csn_pkg::CSN_DRAIN))
        else $error("product outside evaluation");

    // no table write during an evaluation
    a_no_write_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
        any_valid |-> !ram_we)
        else $error("table write overlaps evaluation");
`endif

endmodule

/* rtl/csn_ram.sv */
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module csn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/csn_cos_rom.sv */
// cosine lookup rom, q1.15 samples, registered read
`timescale 1ns / 1ps

module csn_cos_rom #(
    parameter int TABLE_BITS = csn_pkg::COS_TABLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic [TABLE_BITS-1:0]            addr,
    output logic signed [csn_pkg::COS_W-1:0] data
);

    localparam int TABLE_N = 1 << TABLE_BITS;

    logic signed [csn_pkg::COS_W-1:0] rom [TABLE_N];

    // table contents fixed at elaboration
    for (genvar g = 0; g < TABLE_N; g++)
    begin : g_rom
        assign rom[g] = csn_pkg::cos_entry(g, TABLE_BITS);
    end

    // registered read
    always_ff @(posedge clk)
    begin
        data <= rom[addr];
    end

endmodule
